>>> hdl/sprm_pkg.sv
// Shared types, constants and the control store for the stack pattern removal unit.
// Used by every module in hdl/; depends on nothing else.
`default_nettype none

package sprm_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_STACK_DEPTH = 4096;
  localparam int DEF_PATTERN_MAX = 32;

  // Fixed field widths
  localparam int SYM_W      = 8;
  localparam int IDX_W      = 12;
  localparam int OUT_DEPTH_W = 13;
  localparam int LEN_W      = 6;
  localparam int LEN_LIMIT  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_BASE = 3'd1;

  // Microcode field widths
  localparam int PC_W   = 4;
  localparam int ACT_W  = 4;
  localparam int COND_W = 4;

  // Datapath actions
  localparam logic [ACT_W-1:0] A_NOP      = 4'd0;
  localparam logic [ACT_W-1:0] A_FETCH    = 4'd1;
  localparam logic [ACT_W-1:0] A_PUSH     = 4'd2;
  localparam logic [ACT_W-1:0] A_BASE     = 4'd3;
  localparam logic [ACT_W-1:0] A_ISSUE    = 4'd4;
  localparam logic [ACT_W-1:0] A_COMPARE  = 4'd5;
  localparam logic [ACT_W-1:0] A_POP      = 4'd6;
  localparam logic [ACT_W-1:0] A_RD_ISSUE = 4'd7;
  localparam logic [ACT_W-1:0] A_RD_TAKE  = 4'd8;
  localparam logic [ACT_W-1:0] A_OVF      = 4'd9;
  localparam logic [ACT_W-1:0] A_EMIT     = 4'd10;

  // Jump conditions
  localparam logic [COND_W-1:0] C_NEVER    = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS   = 4'd1;
  localparam logic [COND_W-1:0] C_NO_REQ   = 4'd2;
  localparam logic [COND_W-1:0] C_CMD_READ = 4'd3;
  localparam logic [COND_W-1:0] C_FULL     = 4'd4;
  localparam logic [COND_W-1:0] C_NO_CAND  = 4'd5;
  localparam logic [COND_W-1:0] C_CONTINUE = 4'd6;
  localparam logic [COND_W-1:0] C_MISMATCH = 4'd7;
  localparam logic [COND_W-1:0] C_OUT_BUSY = 4'd8;

  // Program addresses
  localparam logic [PC_W-1:0] S_FETCH    = 4'd0;
  localparam logic [PC_W-1:0] S_DISPATCH = 4'd1;
  localparam logic [PC_W-1:0] S_FULLCHK  = 4'd2;
  localparam logic [PC_W-1:0] S_PUSH     = 4'd3;
  localparam logic [PC_W-1:0] S_BASE     = 4'd4;
  localparam logic [PC_W-1:0] S_ISSUE    = 4'd5;
  localparam logic [PC_W-1:0] S_COMPARE  = 4'd6;
  localparam logic [PC_W-1:0] S_VERDICT  = 4'd7;
  localparam logic [PC_W-1:0] S_POP      = 4'd8;
  localparam logic [PC_W-1:0] S_RD_ISSUE = 4'd9;
  localparam logic [PC_W-1:0] S_RD_TAKE  = 4'd10;
  localparam logic [PC_W-1:0] S_OVF      = 4'd11;
  localparam logic [PC_W-1:0] S_EMIT     = 4'd15;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } uword_t;

  typedef struct packed {
    logic req;
    logic cmd_read;
    logic full;
    logic no_cand;
    logic cont;
    logic mismatch;
    logic out_busy;
  } status_t;

  // Control store: jump to target when cond holds, else step to the next word.
  // EMIT sits at the last address so that falling through wraps to FETCH.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{act: A_NOP, cond: C_ALWAYS, target: S_FETCH};
    case (pc)
      S_FETCH:    w = '{act: A_FETCH,    cond: C_NO_REQ,   target: S_FETCH};
      S_DISPATCH: w = '{act: A_NOP,      cond: C_CMD_READ, target: S_RD_ISSUE};
      S_FULLCHK:  w = '{act: A_NOP,      cond: C_FULL,     target: S_OVF};
      S_PUSH:     w = '{act: A_PUSH,     cond: C_NEVER,    target: S_FETCH};
      S_BASE:     w = '{act: A_BASE,     cond: C_NO_CAND,  target: S_EMIT};
      S_ISSUE:    w = '{act: A_ISSUE,    cond: C_NEVER,    target: S_FETCH};
      S_COMPARE:  w = '{act: A_COMPARE,  cond: C_CONTINUE, target: S_COMPARE};
      S_VERDICT:  w = '{act: A_NOP,      cond: C_MISMATCH, target: S_EMIT};
      S_POP:      w = '{act: A_POP,      cond: C_ALWAYS,   target: S_EMIT};
      S_RD_ISSUE: w = '{act: A_RD_ISSUE, cond: C_NEVER,    target: S_FETCH};
      S_RD_TAKE:  w = '{act: A_RD_TAKE,  cond: C_ALWAYS,   target: S_EMIT};
      S_OVF:      w = '{act: A_OVF,      cond: C_ALWAYS,   target: S_EMIT};
      S_EMIT:     w = '{act: A_EMIT,     cond: C_OUT_BUSY, target: S_EMIT};
      default:    w = '{act: A_NOP,      cond: C_ALWAYS,   target: S_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hdl/sprm_sequencer.sv
// Step counter and control store walker for the stack pattern removal unit.
// Depends on sprm_pkg for the control word, action and condition codes.
`default_nettype none

module sprm_sequencer (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire sprm_pkg::status_t        status,
  output logic [sprm_pkg::ACT_W-1:0]    act
);

  logic [sprm_pkg::PC_W-1:0] pc;
  logic [sprm_pkg::PC_W-1:0] pc_next;
  sprm_pkg::uword_t          word;
  logic                      take;

  assign word = sprm_pkg::ucode(pc);
  assign act  = word.act;

  always_comb begin
    case (word.cond)
      sprm_pkg::C_NEVER:    take = 1'b0;
      sprm_pkg::C_ALWAYS:   take = 1'b1;
      sprm_pkg::C_NO_REQ:   take = !status.req;
      sprm_pkg::C_CMD_READ: take = status.cmd_read;
      sprm_pkg::C_FULL:     take = status.full;
      sprm_pkg::C_NO_CAND:  take = status.no_cand;
      sprm_pkg::C_CONTINUE: take = status.cont;
      sprm_pkg::C_MISMATCH: take = status.mismatch;
      sprm_pkg::C_OUT_BUSY: take = status.out_busy;
      default:              take = 1'b0;
    endcase
  end

  assign pc_next = take ? word.target : sprm_pkg::PC_W'(pc + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= sprm_pkg::S_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/sprm_pattern.sv
// Pattern registers and effective length for the stack pattern removal unit.
// Depends on sprm_pkg for register indexes and field widths.
`default_nettype none

module sprm_pattern #(
  parameter int PATTERN_MAX = sprm_pkg::DEF_PATTERN_MAX
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr,
  input  wire logic [sprm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sprm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [$clog2(((PATTERN_MAX < sprm_pkg::LEN_LIMIT) ? PATTERN_MAX
                             : sprm_pkg::LEN_LIMIT) + 1)-1:0] pidx,
  output logic [sprm_pkg::SYM_W-1:0]             pbyte,
  output logic [$clog2(((PATTERN_MAX < sprm_pkg::LEN_LIMIT) ? PATTERN_MAX
                        : sprm_pkg::LEN_LIMIT) + 1)-1:0] n
);

  localparam int LenCap = (PATTERN_MAX < sprm_pkg::LEN_LIMIT) ? PATTERN_MAX
                          : sprm_pkg::LEN_LIMIT;
  localparam int KW  = $clog2(LenCap + 1);
  localparam int PIW = (LenCap > 1) ? $clog2(LenCap) : 1;

  logic [sprm_pkg::LEN_W-1:0] pattern_length;
  logic [sprm_pkg::SYM_W-1:0] pat [LenCap];

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= sprm_pkg::LEN_W'(1);
      for (int b = 0; b < LenCap; b++) begin
        pat[b] <= '0;
      end
    end else if (cfg_wr) begin
      if (cfg_index == sprm_pkg::REG_PAT_LEN) begin
        pattern_length <= cfg_data[sprm_pkg::LEN_W-1:0];
      end
      // Bytes beyond the supported length are never compared; drop them.
      for (int b = 0; b < LenCap; b++) begin
        if (cfg_index == sprm_pkg::CFG_IDX_W'(sprm_pkg::REG_PAT_BASE + (b >> 3))) begin
          pat[b] <= cfg_data[(b & 7) * sprm_pkg::SYM_W +: sprm_pkg::SYM_W];
        end
      end
    end
  end

  // Saturate the configured length at the supported maximum
  assign n = (pattern_length > sprm_pkg::LEN_W'(LenCap)) ? KW'(LenCap)
             : KW'(pattern_length);

  assign pbyte = (pidx < KW'(LenCap)) ? pat[pidx[PIW-1:0]] : '0;

endmodule

`default_nettype wire

>>> hdl/sprm_datapath.sv
// Stack memory, depth counter, compare counter and result register.
// Depends on sprm_pkg; driven by the action code of sprm_sequencer.
`default_nettype none

module sprm_datapath #(
  parameter int STACK_DEPTH = sprm_pkg::DEF_STACK_DEPTH,
  parameter int PATTERN_MAX = sprm_pkg::DEF_PATTERN_MAX
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [sprm_pkg::ACT_W-1:0]         act,
  input  wire logic                               in_valid,
  input  wire logic                               cmd,
  input  wire logic [sprm_pkg::SYM_W-1:0]         symbol,
  input  wire logic [sprm_pkg::IDX_W-1:0]         entry_index,
  input  wire logic                               out_stall,
  input  wire logic [$clog2(((PATTERN_MAX < sprm_pkg::LEN_LIMIT) ? PATTERN_MAX
                             : sprm_pkg::LEN_LIMIT) + 1)-1:0] n,
  input  wire logic [sprm_pkg::SYM_W-1:0]         pbyte,
  output logic [$clog2(((PATTERN_MAX < sprm_pkg::LEN_LIMIT) ? PATTERN_MAX
                        : sprm_pkg::LEN_LIMIT) + 1)-1:0] pidx,
  output sprm_pkg::status_t                       status,
  output logic                                    out_valid,
  output logic [sprm_pkg::OUT_DEPTH_W-1:0]        stack_depth,
  output logic                                    removed,
  output logic                                    overflow,
  output logic [sprm_pkg::SYM_W-1:0]              read_symbol,
  output logic                                    is_empty
);

  localparam int LenCap = (PATTERN_MAX < sprm_pkg::LEN_LIMIT) ? PATTERN_MAX
                          : sprm_pkg::LEN_LIMIT;
  localparam int KW = $clog2(LenCap + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int IW = (AW > sprm_pkg::IDX_W) ? AW : sprm_pkg::IDX_W;
  localparam int CW = (DW > sprm_pkg::IDX_W) ? DW : sprm_pkg::IDX_W;
  localparam int OW = (DW > sprm_pkg::OUT_DEPTH_W) ? DW : sprm_pkg::OUT_DEPTH_W;

  logic [sprm_pkg::SYM_W-1:0] stack_mem [STACK_DEPTH];
  logic [sprm_pkg::SYM_W-1:0] rdata;

  logic                        cmd_r;
  logic [sprm_pkg::SYM_W-1:0]  sym_r;
  logic [sprm_pkg::IDX_W-1:0]  idx_r;
  logic [DW-1:0]               depth;
  logic [AW-1:0]               base;
  logic [KW-1:0]               k;
  logic                        res_removed;
  logic                        res_overflow;
  logic [sprm_pkg::SYM_W-1:0]  res_rd;

  logic          match;
  logic          emit;
  logic          rd_en;
  logic [AW-1:0] raddr;
  logic [IW-1:0] idx_wide;
  logic [DW-1:0] base_full;
  logic [OW-1:0] depth_wide;
  logic          in_range;

  assign match = (rdata == pbyte);
  assign pidx  = (act == sprm_pkg::A_BASE) ? KW'(n - 1'b1) : KW'(k - 1'b1);

  assign status.req      = in_valid;
  assign status.cmd_read = cmd_r;
  assign status.full     = (depth == DW'(STACK_DEPTH));
  assign status.no_cand  = (n == '0) || (depth < DW'(n)) || (sym_r != pbyte);
  assign status.cont     = match && (k < n);
  assign status.mismatch = !match;
  assign status.out_busy = out_valid && out_stall;

  assign emit = (act == sprm_pkg::A_EMIT) && !status.out_busy;

  assign idx_wide  = IW'(idx_r);
  assign base_full = depth - DW'(n);
  assign in_range  = CW'(idx_r) < CW'(depth);
  assign depth_wide = OW'(depth);

  // One stack read per cycle: the next pattern byte while comparing the last
  assign rd_en = (act == sprm_pkg::A_ISSUE) || (act == sprm_pkg::A_RD_ISSUE)
                 || ((act == sprm_pkg::A_COMPARE) && status.cont);
  assign raddr = (act == sprm_pkg::A_RD_ISSUE) ? idx_wide[AW-1:0]
                 : AW'(base + AW'(k));

  always_ff @(posedge clk) begin
    if (act == sprm_pkg::A_PUSH) begin
      stack_mem[depth[AW-1:0]] <= sym_r;
    end
    if (rd_en) begin
      rdata <= stack_mem[raddr];
    end
  end

  // Request capture and working registers
  always_ff @(posedge clk) begin
    case (act)
      sprm_pkg::A_FETCH: begin
        cmd_r <= cmd;
        sym_r <= symbol;
        idx_r <= entry_index;
      end
      sprm_pkg::A_BASE: begin
        base <= base_full[AW-1:0];
        k    <= '0;
      end
      sprm_pkg::A_ISSUE: begin
        k <= KW'(k + 1'b1);
      end
      sprm_pkg::A_COMPARE: begin
        if (status.cont) begin
          k <= KW'(k + 1'b1);
        end
      end
      sprm_pkg::A_RD_TAKE: begin
        res_rd <= in_range ? rdata : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth        <= '0;
      res_removed  <= 1'b0;
      res_overflow <= 1'b0;
    end else begin
      case (act)
        sprm_pkg::A_FETCH: begin
          res_removed  <= 1'b0;
          res_overflow <= 1'b0;
        end
        sprm_pkg::A_PUSH: begin
          depth <= DW'(depth + 1'b1);
        end
        sprm_pkg::A_POP: begin
          depth       <= DW'(base);
          res_removed <= 1'b1;
        end
        sprm_pkg::A_OVF: begin
          res_overflow <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: holds the result until taken, frees the engine meanwhile
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      stack_depth <= depth_wide[sprm_pkg::OUT_DEPTH_W-1:0];
      removed     <= res_removed;
      overflow    <= res_overflow;
      read_symbol <= cmd_r ? res_rd : '0;
      is_empty    <= (depth == '0);
    end
  end

endmodule

`default_nettype wire

>>> hdl/stack_pattern_removal_unit.sv
// Top level of the stack pattern removal unit: sequencer, datapath and pattern registers.
// Depends on sprm_pkg, sprm_sequencer, sprm_datapath and sprm_pattern.
//
// Each push request lands on a byte stack; when the stack top could end in the
// configured pattern, the top entries are compared one per cycle and popped on a
// full match; no further compare follows a removal. A read request returns the
// entry at entry_index (0 past the depth), and every request gives one result
// with the depth and an empty flag. The compare is paced by the single read port
// of the stack memory, which yields one stored byte per cycle. One request is
// worked on at a time; the next is accepted while the previous result waits in
// the output register. The stack needs no clearing after reset. Configuration
// writes are taken at any time out of reset and must only be issued while the
// unit is idle.
`default_nettype none

module stack_pattern_removal_unit #(
  parameter int STACK_DEPTH = sprm_pkg::DEF_STACK_DEPTH,
  parameter int PATTERN_MAX = sprm_pkg::DEF_PATTERN_MAX
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sprm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sprm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             cmd,
  input  wire logic [sprm_pkg::SYM_W-1:0]       symbol,
  input  wire logic [sprm_pkg::IDX_W-1:0]       entry_index,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [sprm_pkg::OUT_DEPTH_W-1:0]      stack_depth,
  output logic                                  removed,
  output logic                                  overflow,
  output logic [sprm_pkg::SYM_W-1:0]            read_symbol,
  output logic                                  is_empty
);

  localparam int LenCap = (PATTERN_MAX < sprm_pkg::LEN_LIMIT) ? PATTERN_MAX
                          : sprm_pkg::LEN_LIMIT;
  localparam int KW = $clog2(LenCap + 1);

  logic [sprm_pkg::ACT_W-1:0] act;
  sprm_pkg::status_t          status;
  logic [KW-1:0]              n;
  logic [KW-1:0]              pidx;
  logic [sprm_pkg::SYM_W-1:0] pbyte;

  assign cfg_ready = !rst;
  assign in_stall  = rst || (act != sprm_pkg::A_FETCH);

  sprm_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .act    (act)
  );

  sprm_pattern #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_pat (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pidx      (pidx),
    .pbyte     (pbyte),
    .n         (n)
  );

  sprm_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .PATTERN_MAX (PATTERN_MAX)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .act         (act),
    .in_valid    (in_valid),
    .cmd         (cmd),
    .symbol      (symbol),
    .entry_index (entry_index),
    .out_stall   (out_stall),
    .n           (n),
    .pbyte       (pbyte),
    .pidx        (pidx),
    .status      (status),
    .out_valid   (out_valid),
    .stack_depth (stack_depth),
    .removed     (removed),
    .overflow    (overflow),
    .read_symbol (read_symbol),
    .is_empty    (is_empty)
  );

endmodule

`default_nettype wire
